>>> rtl/ptpa_pkg.sv
package ptpa_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ALIGN = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // operation codes, the last one does nothing
    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_INIT  = 2'd2,
        FN_NOP   = 2'd3
    } func_t;

    // pool selector codes
    localparam logic [1:0] POOL_TOP  = 2'd0;
    localparam logic [1:0] POOL_MID  = 2'd1;
    localparam logic [1:0] POOL_LEAF = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_AREA_BASE  = 2'd0;
    localparam logic [1:0] CFG_AREA_ORDER = 2'd1;
    localparam logic [1:0] CFG_TOP_ORDER  = 2'd2;
    localparam logic [1:0] CFG_MID_ORDER  = 2'd3;

    // configuration reset values
    localparam logic [63:0] RST_AREA_BASE  = 64'd0;
    localparam logic [3:0]  RST_AREA_ORDER = 4'd12;
    localparam logic [3:0]  RST_TOP_ORDER  = 4'd8;
    localparam logic [3:0]  RST_MID_ORDER  = 4'd10;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

>>> rtl/page_table_page_pool_allocator.sv
// flow: a taken input is captured, then committed into the result registers in the exec state,
//   which waits while the output is full and stalled; no new item is taken before that commit,
//   as a pop needs the registered read of the link memory before the next item uses the new head
// reset: asynchronous active-low rst_n restores the control, configuration and pool registers,
//   empties all freed stacks, refills the untouched marks and free count; the link memory is not cleared
module page_table_page_pool_allocator #(
    parameter int AREA_PAGES = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           func,
    input  logic [1:0]                           pool,
    input  logic [63:0]                          page_addr,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [63:0]                          alloc_addr,
    output logic [$clog2(AREA_PAGES + 1) - 1:0]  free_count,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [63:0]                          cfg_data
);

    // capture/commit strobes from the sequencer
    ptpa_pkg::cmd_t cmd;

    // register writes are always taken; the user must only write while the block is idle, not enforced
    assign cfg_ready = 1'b1;

    // sequencer: idle -> exec, holds exec while the output register is full and stalled
    ptpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: pool layout, per-pool stacks and marks, link memory, result registers
    // capture cycle: selects the pool state, starts the link read, forms the page offset
    // commit cycle: range check, pop/push, count update and result load
    ptpa_dp #(
        .AREA_PAGES (AREA_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (func),
        .pool       (pool),
        .page_addr  (page_addr),
        .status     (status),
        .alloc_addr (alloc_addr),
        .free_count (free_count)
    );

endmodule

>>> rtl/ptpa_ctrl.sv
module ptpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output ptpa_pkg::cmd_t    cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.capture = in_valid && !in_stall_reg;
        cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result loads as the old one leaves, otherwise the register drains
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.capture)
                    begin
                        state_reg    <= S_EXEC;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    if (cmd.commit)
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/ptpa_dp.sv
module ptpa_dp #(
    parameter int AREA_PAGES = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ptpa_pkg::cmd_t                       cmd,
    input  logic                                 cfg_valid,
    input  logic [1:0]                           cfg_index,
    input  logic [63:0]                          cfg_data,
    input  logic [1:0]                           func,
    input  logic [1:0]                           pool,
    input  logic [63:0]                          page_addr,
    output logic [1:0]                           status,
    output logic [63:0]                          alloc_addr,
    output logic [$clog2(AREA_PAGES + 1) - 1:0]  free_count
);

    localparam int PW  = $clog2(AREA_PAGES);
    localparam int CW  = $clog2(AREA_PAGES + 1);
    localparam int OW  = CW + 1;
    localparam int SW  = (CW > 16) ? CW : 16;
    localparam int PBW = $clog2(PAGE_BYTES);

    typedef struct packed {
        logic [CW-1:0] area;
        logic [CW-1:0] top;
        logic [CW-1:0] mid;
        logic [CW-1:0] leaf;
    } span_t;

    function automatic span_t pool_sizes(input logic [3:0] ao, input logic [3:0] to,
                                         input logic [3:0] mo);
        logic [SW-1:0] area;
        logic [SW-1:0] top;
        logic [SW-1:0] mid;
        span_t         res;
        area = SW'(1) << ao;
        if (area > SW'(AREA_PAGES))
        begin
            area = SW'(AREA_PAGES);
        end
        top = SW'(1) << to;
        if (top > area)
        begin
            top = area;
        end
        mid = SW'(1) << mo;
        if (mid > area - top)
        begin
            mid = area - top;
        end
        res.area = CW'(area);
        res.top  = CW'(top);
        res.mid  = CW'(mid);
        res.leaf = CW'(area - top - mid);
        return res;
    endfunction

    // configuration
    logic [63:0] area_base_reg;
    logic [3:0]  area_order_reg;
    logic [3:0]  top_order_reg;
    logic [3:0]  mid_order_reg;

    // per pool state
    logic [PW-1:0] head_reg   [3];
    logic          hvalid_reg [3];
    logic [CW-1:0] mark_reg   [3];
    logic [CW-1:0] pages_free_reg;

    // link memory: {link valid, next page}
    logic [PW:0] link_mem [AREA_PAGES];
    logic [PW:0] rd_reg;

    // captured item
    logic [1:0]    func_reg;
    logic [1:0]    pool_reg;
    logic          lowbits_reg;
    logic [63:0]   diff_reg;
    logic [PW-1:0] hd_reg;
    logic          hv_reg;
    logic [CW-1:0] mk_reg;
    logic [CW-1:0] start_reg;
    logic [CW-1:0] size_reg;

    // result
    ptpa_pkg::status_t status_reg;
    logic [63:0]       addr_reg;
    logic [CW-1:0]     count_reg;

    span_t spans;
    span_t rst_spans;

    // selection at capture
    logic [PW-1:0] sel_head;
    logic          sel_hv;
    logic [CW-1:0] sel_mark;
    logic [CW-1:0] sel_start;
    logic [CW-1:0] sel_size;

    // commit decisions
    ptpa_pkg::status_t st_next;
    logic [63:0]       addr_next;
    logic [CW-1:0]     count_next;
    logic              do_pop;
    logic              do_take;
    logic              do_push;
    logic              do_init;
    logic [63:0]       rel;
    logic [CW-1:0]     mark_dec;
    logic [CW-1:0]     fp_sum;
    // marks kept across a layout change can reach past the area
    logic [OW-1:0]     up_sum;
    logic [PW-1:0]     push_page;
    logic [OW-1:0]     out_page;

    assign spans     = pool_sizes(area_order_reg, top_order_reg, mid_order_reg);
    assign rst_spans = pool_sizes(ptpa_pkg::RST_AREA_ORDER, ptpa_pkg::RST_TOP_ORDER,
                                  ptpa_pkg::RST_MID_ORDER);

    always_comb
    begin
        sel_head  = '0;
        sel_hv    = 1'b0;
        sel_mark  = '0;
        sel_start = '0;
        sel_size  = '0;
        case (pool)
            ptpa_pkg::POOL_TOP:
            begin
                sel_head  = head_reg[0];
                sel_hv    = hvalid_reg[0];
                sel_mark  = mark_reg[0];
                sel_start = '0;
                sel_size  = spans.top;
            end
            ptpa_pkg::POOL_MID:
            begin
                sel_head  = head_reg[1];
                sel_hv    = hvalid_reg[1];
                sel_mark  = mark_reg[1];
                sel_start = spans.top;
                sel_size  = spans.mid;
            end
            ptpa_pkg::POOL_LEAF:
            begin
                sel_head  = head_reg[2];
                sel_hv    = hvalid_reg[2];
                sel_mark  = mark_reg[2];
                sel_start = spans.top + spans.mid;
                sel_size  = spans.leaf;
            end
            default:
            begin
                sel_head = '0;
            end
        endcase
    end

    always_comb
    begin
        rel       = diff_reg - 64'(start_reg);
        mark_dec  = mk_reg - CW'(1);
        fp_sum    = start_reg + rel[CW-1:0];
        up_sum    = OW'(start_reg) + OW'(mark_dec);
        push_page = fp_sum[PW-1:0];
        out_page  = hv_reg ? OW'(hd_reg) : up_sum;
        st_next   = ptpa_pkg::ST_OK;
        addr_next = '0;
        count_next = pages_free_reg;
        do_pop    = 1'b0;
        do_take   = 1'b0;
        do_push   = 1'b0;
        do_init   = 1'b0;
        case (ptpa_pkg::func_t'(func_reg))
            ptpa_pkg::FN_ALLOC:
            begin
                if (pool_reg > ptpa_pkg::POOL_LEAF)
                begin
                    st_next = ptpa_pkg::ST_EMPTY;
                end
                else if (hv_reg || (mk_reg != '0))
                begin
                    do_pop    = hv_reg;
                    do_take   = !hv_reg;
                    addr_next = area_base_reg + (64'(out_page) << PBW);
                    if (pages_free_reg != '0)
                    begin
                        count_next = pages_free_reg - CW'(1);
                    end
                end
                else
                begin
                    st_next = ptpa_pkg::ST_EMPTY;
                end
            end
            ptpa_pkg::FN_FREE:
            begin
                if (lowbits_reg)
                begin
                    st_next = ptpa_pkg::ST_ALIGN;
                end
                else if (pool_reg > ptpa_pkg::POOL_LEAF)
                begin
                    st_next = ptpa_pkg::ST_RANGE;
                end
                else if (rel >= 64'(size_reg))
                begin
                    st_next = ptpa_pkg::ST_RANGE;
                end
                else
                begin
                    do_push = 1'b1;
                    if (pages_free_reg < CW'(AREA_PAGES))
                    begin
                        count_next = pages_free_reg + CW'(1);
                    end
                end
            end
            ptpa_pkg::FN_INIT:
            begin
                do_init    = 1'b1;
                count_next = spans.area;
            end
            default:
            begin
                st_next = ptpa_pkg::ST_OK;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_base_reg  <= ptpa_pkg::RST_AREA_BASE;
            area_order_reg <= ptpa_pkg::RST_AREA_ORDER;
            top_order_reg  <= ptpa_pkg::RST_TOP_ORDER;
            mid_order_reg  <= ptpa_pkg::RST_MID_ORDER;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ptpa_pkg::CFG_AREA_BASE:  area_base_reg  <= cfg_data;
                ptpa_pkg::CFG_AREA_ORDER: area_order_reg <= cfg_data[3:0];
                ptpa_pkg::CFG_TOP_ORDER:  top_order_reg  <= cfg_data[3:0];
                ptpa_pkg::CFG_MID_ORDER:  mid_order_reg  <= cfg_data[3:0];
                default:                  area_base_reg  <= area_base_reg;
            endcase
        end
    end

    // pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i]   <= '0;
                hvalid_reg[i] <= 1'b0;
            end
            mark_reg[0]    <= rst_spans.top;
            mark_reg[1]    <= rst_spans.mid;
            mark_reg[2]    <= rst_spans.leaf;
            pages_free_reg <= rst_spans.area;
        end
        else if (cmd.commit)
        begin
            pages_free_reg <= count_next;
            if (do_init)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hvalid_reg[i] <= 1'b0;
                end
                mark_reg[0] <= spans.top;
                mark_reg[1] <= spans.mid;
                mark_reg[2] <= spans.leaf;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (pool_reg == 2'(i))
                begin
                    if (do_pop)
                    begin
                        // follow the link, or the stack runs dry
                        if (rd_reg[PW])
                        begin
                            head_reg[i] <= rd_reg[PW-1:0];
                        end
                        else
                        begin
                            hvalid_reg[i] <= 1'b0;
                        end
                    end
                    if (do_take)
                    begin
                        mark_reg[i] <= mark_dec;
                    end
                    if (do_push)
                    begin
                        head_reg[i]   <= push_page;
                        hvalid_reg[i] <= 1'b1;
                    end
                end
            end
        end
    end

    // captured item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= func;
            pool_reg    <= pool;
            lowbits_reg <= |page_addr[PBW-1:0];
            diff_reg    <= (page_addr - area_base_reg) >> PBW;
            hd_reg      <= sel_head;
            hv_reg      <= sel_hv;
            mk_reg      <= sel_mark;
            start_reg   <= sel_start;
            size_reg    <= sel_size;
        end
        if (cmd.commit)
        begin
            status_reg <= st_next;
            addr_reg   <= addr_next;
            count_reg  <= count_next;
        end
    end

    // link memory, one read port and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_reg <= link_mem[sel_head];
        end
        if (cmd.commit && do_push)
        begin
            link_mem[push_page] <= {hv_reg, hd_reg};
        end
    end

    assign status     = status_reg;
    assign alloc_addr = addr_reg;
    assign free_count = count_reg;

endmodule

>>> rtl/ptpa_checker.sv
module ptpa_checker #(
    parameter int AREA_PAGES = 4096
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [1:0]                           status,
    input logic [63:0]                          alloc_addr,
    input logic [$clog2(AREA_PAGES + 1) - 1:0]  free_count
);

    localparam int CW = $clog2(AREA_PAGES + 1);

    // one item in flight: a new transaction is refused right after one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous item still in flight");

    // an error result never carries an address
    a_err_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ptpa_pkg::ST_OK)) |-> (alloc_addr == 64'd0))
        else $error("error result with nonzero address");

    // free count never exceeds the area
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_count <= CW'(AREA_PAGES)))
        else $error("free count above area size");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(alloc_addr)
                                      && $stable(free_count)))
        else $error("stalled result changed");

endmodule

bind page_table_page_pool_allocator ptpa_checker #(
    .AREA_PAGES (AREA_PAGES)
) u_ptpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .alloc_addr (alloc_addr),
    .free_count (free_count)
);

>>> bench/page_table_page_pool_allocator_tb.sv
module page_table_page_pool_allocator_tb;

    localparam int AREA_PAGES = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int CNT_W = $clog2(AREA_PAGES + 1);
    // cycles with no transaction on any channel before the run is abandoned
    localparam int STUCK_LIMIT = 5000;
    // length of the forced receiver hold-off that backs up the block
    localparam int HOLD_CYCLES = 300;
    // selector value past the last pool
    localparam logic [1:0] POOL_NONE = 2'd3;

    // one result transaction as the block should present it
    typedef struct {
        ptpa_pkg::status_t st;
        logic [63:0]       addr;
        logic [CNT_W-1:0]  count;
    } page_result_t;

    // tracks pool state, predicts each result and compares it on arrival
    class page_pool_tracker;
        logic [63:0]  base;
        logic [3:0]   area_ord;
        logic [3:0]   top_ord;
        logic [3:0]   mid_ord;
        int unsigned  next_link [AREA_PAGES];
        bit           next_ok [AREA_PAGES];
        int unsigned  stack_head [3];
        bit           head_ok [3];
        int unsigned  fresh_left [3];
        int unsigned  free_pages;
        logic [63:0]  held [3][$];
        page_result_t due_results [$];
        int           errors;

        function new();
            base = ptpa_pkg::RST_AREA_BASE;
            area_ord = ptpa_pkg::RST_AREA_ORDER;
            top_ord = ptpa_pkg::RST_TOP_ORDER;
            mid_ord = ptpa_pkg::RST_MID_ORDER;
            foreach (next_ok[i]) next_ok[i] = 1'b0;
            errors = 0;
            rebuild();
        endfunction

        function int unsigned area_pages();
            int unsigned n;
            n = 32'd1 << area_ord;
            return (n > AREA_PAGES) ? AREA_PAGES : n;
        endfunction

        function void span(input int p, output int unsigned start, output int unsigned size);
            int unsigned area;
            int unsigned top;
            int unsigned mid;
            area = area_pages();
            top = 32'd1 << top_ord;
            mid = 32'd1 << mid_ord;
            if (top > area) top = area;
            if (mid > area - top) mid = area - top;
            if (p == ptpa_pkg::POOL_TOP)
            begin
                start = 0;
                size = top;
            end
            else if (p == ptpa_pkg::POOL_MID)
            begin
                start = top;
                size = mid;
            end
            else
            begin
                start = top + mid;
                size = area - top - mid;
            end
        endfunction

        function void rebuild();
            int unsigned s;
            int unsigned n;
            for (int p = 0; p < 3; p++)
            begin
                span(p, s, n);
                fresh_left[p] = n;
                head_ok[p] = 1'b0;
                stack_head[p] = 0;
                held[p].delete();
            end
            free_pages = area_pages();
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [63:0] val);
            case (idx)
                ptpa_pkg::CFG_AREA_BASE:  base = val;
                ptpa_pkg::CFG_AREA_ORDER: area_ord = val[3:0];
                ptpa_pkg::CFG_TOP_ORDER:  top_ord = val[3:0];
                default:                  mid_ord = val[3:0];
            endcase
        endfunction

        function void take_request(input logic [1:0] f, input logic [1:0] p,
                                   input logic [63:0] a);
            ptpa_pkg::status_t st;
            logic [63:0]       addr;
            logic [63:0]       rel;
            int unsigned       start;
            int unsigned       size;
            int unsigned       pg;
            page_result_t      r;
            st = ptpa_pkg::ST_OK;
            addr = '0;
            case (f)
                ptpa_pkg::FN_ALLOC:
                begin
                    if (p > ptpa_pkg::POOL_LEAF)
                    begin
                        st = ptpa_pkg::ST_EMPTY;
                    end
                    else if (head_ok[p])
                    begin
                        // most recently freed page first
                        pg = stack_head[p];
                        if (next_ok[pg]) stack_head[p] = next_link[pg];
                        else head_ok[p] = 1'b0;
                        addr = base + 64'(pg) * 64'(PAGE_BYTES);
                        if (free_pages > 0) free_pages--;
                        held[p].push_back(addr);
                    end
                    else if (fresh_left[p] > 0)
                    begin
                        span(p, start, size);
                        fresh_left[p]--;
                        addr = base + 64'(start + fresh_left[p]) * 64'(PAGE_BYTES);
                        if (free_pages > 0) free_pages--;
                        held[p].push_back(addr);
                    end
                    else
                    begin
                        st = ptpa_pkg::ST_EMPTY;
                    end
                end
                ptpa_pkg::FN_FREE:
                begin
                    if (a % 64'(PAGE_BYTES) != 0)
                    begin
                        st = ptpa_pkg::ST_ALIGN;
                    end
                    else if (p > ptpa_pkg::POOL_LEAF)
                    begin
                        st = ptpa_pkg::ST_RANGE;
                    end
                    else
                    begin
                        span(p, start, size);
                        rel = (a - base) / 64'(PAGE_BYTES) - 64'(start);
                        if (rel >= 64'(size))
                        begin
                            st = ptpa_pkg::ST_RANGE;
                        end
                        else
                        begin
                            pg = start + 32'(rel);
                            if (pg < AREA_PAGES)
                            begin
                                next_link[pg] = stack_head[p];
                                next_ok[pg] = head_ok[p];
                                stack_head[p] = pg;
                                head_ok[p] = 1'b1;
                                if (free_pages < AREA_PAGES) free_pages++;
                            end
                            else
                            begin
                                st = ptpa_pkg::ST_RANGE;
                            end
                        end
                    end
                end
                ptpa_pkg::FN_INIT: rebuild();
                default: ;
            endcase
            r.st = st;
            r.addr = addr;
            r.count = CNT_W'(free_pages);
            due_results.push_back(r);
        endfunction

        function void match_result(input logic [1:0] st, input logic [63:0] addr,
                                   input logic [CNT_W-1:0] cnt);
            page_result_t r;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d addr %h count %0d",
                         $time, st, addr, cnt);
                errors++;
            end
            else
            begin
                r = due_results.pop_front();
                if (st !== r.st)
                begin
                    $display("%0t: status expected %0d got %0d", $time, r.st, st);
                    errors++;
                end
                if (addr !== r.addr)
                begin
                    $display("%0t: alloc_addr expected %h got %h", $time, r.addr, addr);
                    errors++;
                end
                if (cnt !== r.count)
                begin
                    $display("%0t: free_count expected %0d got %0d", $time, r.count, cnt);
                    errors++;
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        func = ptpa_pkg::FN_NOP;
    logic [1:0]        pool = ptpa_pkg::POOL_TOP;
    logic [63:0]       page_addr = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [63:0]       alloc_addr;
    logic [CNT_W-1:0]  free_count;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = ptpa_pkg::CFG_AREA_BASE;
    logic [63:0]       cfg_data = '0;

    // idling controls shared between the stimulus and the receiver
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit rx_hold_req = 1'b0;

    page_pool_tracker tracker = new();

    page_table_page_pool_allocator #(
        .AREA_PAGES (AREA_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .pool       (pool),
        .page_addr  (page_addr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .alloc_addr (alloc_addr),
        .free_count (free_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_result(status, alloc_addr, free_count);
    end

    // receiver: random stall segments, mostly short, plus one long forced hold-off
    initial
    begin
        int rx_left;
        int r;
        bit rx_on;
        rx_left = 0;
        rx_on = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_left <= 0)
            begin
                r = $urandom_range(0, 99);
                if (rx_hold_req)
                begin
                    rx_hold_req = 1'b0;
                    rx_on = 1'b1;
                    rx_left = HOLD_CYCLES;
                end
                else if (rx_quiet)
                begin
                    rx_on = 1'b0;
                    rx_left = 1;
                end
                else if (r < 45)
                begin
                    rx_on = 1'b0;
                    rx_left = $urandom_range(1, 20);
                end
                else if (r < 80)
                begin
                    rx_on = 1'b1;
                    rx_left = $urandom_range(1, 3);
                end
                else if (r < 95)
                begin
                    rx_on = 1'b1;
                    rx_left = $urandom_range(4, 12);
                end
                else
                begin
                    rx_on = 1'b1;
                    rx_left = $urandom_range(20, 60);
                end
            end
            out_stall <= rx_on;
            rx_left--;
        end
    end

    // watchdog: abandon the run when no transaction moves for too long
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                    || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("FAIL page_table_page_pool_allocator");
        $finish;
    end

    // sender gap, mostly back to back with the odd long pause
    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one input transaction and hold it until accepted
    task automatic send(input logic [1:0] f, input logic [1:0] p, input logic [63:0] a);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        pool <= p;
        page_addr <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_request(f, p, a);
    endtask

    // stop offering and let every predicted result come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.write_reg(idx, val);
    endtask

    // registers only change with the block idle
    task automatic set_layout(input logic [63:0] base, input logic [3:0] ao,
                              input logic [3:0] to, input logic [3:0] mo);
        wait_idle();
        write_reg(ptpa_pkg::CFG_AREA_BASE, base);
        write_reg(ptpa_pkg::CFG_AREA_ORDER, 64'(ao));
        write_reg(ptpa_pkg::CFG_TOP_ORDER, 64'(to));
        write_reg(ptpa_pkg::CFG_MID_ORDER, 64'(mo));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly allocate and give back pages that were handed out, with some noise
    task automatic random_item();
        int r;
        int q;
        int k;
        logic [1:0] p;
        logic [63:0] a;
        p = ($urandom_range(0, 19) == 0) ? POOL_NONE : 2'($urandom_range(0, 2));
        a = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            send(ptpa_pkg::FN_ALLOC, p, a);
        end
        else if (r < 80)
        begin
            q = $urandom_range(0, 2);
            if (tracker.held[q].size() > 0)
            begin
                k = $urandom_range(0, tracker.held[q].size() - 1);
                a = tracker.held[q][k];
                tracker.held[q].delete(k);
                // now and then hand it back to the wrong pool
                if ($urandom_range(0, 9) == 0) q = (q + 1) % 3;
                send(ptpa_pkg::FN_FREE, 2'(q), a);
            end
            else
            begin
                send(ptpa_pkg::FN_ALLOC, 2'(q), a);
            end
        end
        else if (r < 85)
        begin
            // any page of the area, which may be a double free or a range error
            k = $urandom_range(0, tracker.area_pages() - 1);
            send(ptpa_pkg::FN_FREE, p, tracker.base + 64'(k) * 64'(PAGE_BYTES));
        end
        else if (r < 90)
        begin
            send(ptpa_pkg::FN_FREE, p, a);
        end
        else if (r < 93)
        begin
            send(ptpa_pkg::FN_FREE, p, a & ~64'(PAGE_BYTES - 1));
        end
        else if (r < 96)
        begin
            send(ptpa_pkg::FN_INIT, p, a);
        end
        else
        begin
            send(ptpa_pkg::FN_NOP, p, a);
        end
    endtask

    task automatic run_phase(input logic [63:0] base, input logic [3:0] ao,
                             input logic [3:0] to, input logic [3:0] mo,
                             input int n, input bit reinit, input bit hold);
        set_layout(base, ao, to, mo);
        if (reinit) send(ptpa_pkg::FN_INIT, ptpa_pkg::POOL_TOP, '0);
        // some phases run with no idling at all
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        // the receiver holds off while the sender keeps offering
        rx_hold_req = hold;
        repeat (n) random_item();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout: top 256, middle 1024, leaf 2816 pages from address zero
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_TOP, '1);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_MID, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_LEAF, '0);
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_TOP, 64'h000F_F000);
        // a never allocated page is taken back too
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_TOP, 64'h0);
        // freed pages come back last in first out, then untouched ones
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_TOP, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_TOP, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_TOP, '0);
        // misaligned addresses, all ones and a single low bit
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_TOP, '1);
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_TOP, 64'h800);
        // selector past the last pool
        send(ptpa_pkg::FN_FREE, POOL_NONE, 64'h1000);
        send(ptpa_pkg::FN_ALLOC, POOL_NONE, '0);
        // below the base wraps to a huge index, a top page given to the middle pool,
        // and the first page past the leaf pool
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_LEAF, 64'hFFFF_FFFF_FFFF_F000);
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_MID, 64'h1000);
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_LEAF, 64'h0100_0000);
        // double free goes undetected, the page comes out twice
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_LEAF, 64'h00FF_F000);
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_LEAF, 64'h00FF_F000);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_LEAF, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_LEAF, '0);
        send(ptpa_pkg::FN_NOP, POOL_NONE, '1);
        // a free with every page already free leaves the count at its ceiling
        send(ptpa_pkg::FN_INIT, ptpa_pkg::POOL_LEAF, '0);
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_TOP, 64'h0);

        // two page area at the top of the address space: one top, one middle, no leaf
        set_layout(64'hFFFF_FFFF_FFFF_F000, 4'd1, 4'd0, 4'd0);
        send(ptpa_pkg::FN_INIT, ptpa_pkg::POOL_TOP, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_LEAF, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_TOP, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_TOP, '0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_MID, '0);
        // base plus one page wraps to address zero
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_MID, 64'h0);
        send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_MID, '0);

        // drain a sixteen page area after an extra free: every pool runs dry, count hits zero
        set_layout(ptpa_pkg::RST_AREA_BASE, 4'd4, 4'd2, 4'd3);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send(ptpa_pkg::FN_INIT, ptpa_pkg::POOL_TOP, '0);
        send(ptpa_pkg::FN_FREE, ptpa_pkg::POOL_TOP, 64'h0);
        repeat (6) send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_TOP, '0);
        repeat (9) send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_MID, '0);
        repeat (5) send(ptpa_pkg::FN_ALLOC, ptpa_pkg::POOL_LEAF, '0);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // random traffic over several layouts, the first one under a long hold-off
        run_phase(ptpa_pkg::RST_AREA_BASE, ptpa_pkg::RST_AREA_ORDER, ptpa_pkg::RST_TOP_ORDER,
                  ptpa_pkg::RST_MID_ORDER, 100, 1'b1, 1'b1);
        // leaf pool empty, middle pool fills the rest of the area
        run_phase(64'hFFFF_FFFF_FFFF_F000, 4'd12, 4'd11, 4'd11, 90, 1'b1, 1'b0);
        run_phase({$urandom, $urandom} & ~64'(PAGE_BYTES - 1), 4'd1, 4'd0, 4'd0, 80,
                  1'b1, 1'b0);
        run_phase({$urandom, $urandom} & ~64'(PAGE_BYTES - 1), 4'd4, 4'd2, 4'd3, 100,
                  1'b1, 1'b0);
        // top pool clamped to the area, middle pool empty
        run_phase({$urandom, $urandom} & ~64'(PAGE_BYTES - 1), 4'd3, 4'd11, 4'd0, 80,
                  1'b1, 1'b0);
        run_phase({$urandom, $urandom} & ~64'(PAGE_BYTES - 1), 4'd6, 4'd0, 4'd5, 100,
                  1'b1, 1'b0);
        // new layout without rebuilding: marks and count stay from the last phase
        run_phase({$urandom, $urandom} & ~64'(PAGE_BYTES - 1),
                  4'($urandom_range(1, 12)), 4'($urandom_range(0, 11)),
                  4'($urandom_range(0, 11)), 100, 1'b0, 1'b0);

        wait_idle();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("PASS page_table_page_pool_allocator");
        else
            $display("FAIL page_table_page_pool_allocator");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ptpa_pkg.sv
rtl/ptpa_ctrl.sv
rtl/ptpa_dp.sv
rtl/page_table_page_pool_allocator.sv
rtl/ptpa_checker.sv
bench/page_table_page_pool_allocator_tb.sv
